### rtl/core/mwpt_pkg.sv
`default_nettype none

package mwpt_pkg;

    // Field widths
    localparam int POS_W      = 32;
    localparam int ANG_W      = 16;
    localparam int RES_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int SC_W   = 32;              // cosine / sine, signed Q.30
    localparam int AX_W   = POS_W + 1;       // operand after origin subtraction
    localparam int PR_W   = SC_W + AX_W;     // one rotation product
    localparam int SUM_W  = PR_W + 1;        // sum of two products
    localparam int RND_SH = 30;
    localparam int R_W    = SUM_W - RND_SH;  // rotated value, Q.16
    localparam int MP_W   = R_W + RES_W + 1; // rotated value times resolution
    localparam int SC_SH  = 16;
    localparam int RS_W   = MP_W - SC_SH;
    localparam int OS_W   = RS_W + 1;        // scaled value plus origin
    localparam int DVD_W  = R_W + SC_SH + 1; // dividend for world to map
    localparam int Q_W    = POS_W + 1;       // quotient bits kept
    localparam int REM_W  = RES_W + Q_W;     // partial remainder
    localparam int CZ_W   = 34;              // CORDIC x, y and angle

    localparam logic signed [CZ_W-1:0] CORDIC_GAIN = 34'sd652032874;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_YAW = 3'd3;

    // Commands
    localparam logic CMD_M2W = 1'b0;
    localparam logic CMD_W2M = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic signed [POS_W-1:0] pose_x;
        logic signed [POS_W-1:0] pose_y;
        logic signed [ANG_W-1:0] heading;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [ANG_W-1:0] out_heading;
        logic                    saturated;
    } t_out;

    typedef enum logic [1:0] {
        CS_LOAD,
        CS_ITER,
        CS_DONE,
        CS_IDLE
    } t_cordic_state;

    // One item on its way through the divider stages
    typedef struct packed {
        logic                    cmd;
        logic [ANG_W-1:0]        hd;
        logic [POS_W-1:0]        mx;
        logic [POS_W-1:0]        my;
        logic                    mclip;
        logic                    nx;
        logic                    ny;
        logic                    ovx;
        logic                    ovy;
        logic [REM_W-1:0]        rx;
        logic [REM_W-1:0]        ry;
        logic [Q_W-1:0]          qx;
        logic [Q_W-1:0]          qy;
        logic [RES_W-1:0]        dv;
    } t_lane;

    // atan(2^-i), 2^32 per turn
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/core/mwpt_cordic.sv
`default_nettype none

module mwpt_cordic #(
    parameter int ITER = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire        [mwpt_pkg::ANG_W-1:0]    i_yaw,
    output logic signed [mwpt_pkg::SC_W-1:0]    o_cos,
    output logic signed [mwpt_pkg::SC_W-1:0]    o_sin,
    output logic                                o_busy
);

    localparam int CNT_W = $clog2(ITER);

    mwpt_pkg::t_cordic_state r_state, n_state;

    logic signed [mwpt_pkg::CZ_W-1:0] r_x, r_y, r_z;
    logic [CNT_W-1:0]                 r_cnt;
    logic                             r_flip;
    logic signed [mwpt_pkg::SC_W-1:0] r_cos, r_sin;

    logic [31:0]                      z32;
    logic                             flip;
    logic signed [mwpt_pkg::CZ_W-1:0] xs, ys, at;

    // Fold the angle into the right half plane
    always_comb begin
        z32  = {i_yaw, 16'b0};
        flip = (z32[31:30] == 2'b01) || (z32[31:30] == 2'b10);
        z32[31] = z32[31] ^ flip;
        xs = r_x >>> r_cnt;
        ys = r_y >>> r_cnt;
        at = mwpt_pkg::CZ_W'(mwpt_pkg::atan_turns(5'(r_cnt)));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mwpt_pkg::CS_LOAD: n_state = mwpt_pkg::CS_ITER;
            mwpt_pkg::CS_ITER: begin
                if (r_cnt == CNT_W'(ITER - 1)) n_state = mwpt_pkg::CS_DONE;
            end
            mwpt_pkg::CS_DONE: n_state = mwpt_pkg::CS_IDLE;
            mwpt_pkg::CS_IDLE: n_state = mwpt_pkg::CS_IDLE;
            default:           n_state = mwpt_pkg::CS_LOAD;
        endcase
        if (i_start) n_state = mwpt_pkg::CS_LOAD;
    end

    // Outputs
    always_comb begin
        o_busy = (r_state != mwpt_pkg::CS_IDLE);
        o_cos  = r_cos;
        o_sin  = r_sin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwpt_pkg::CS_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Load, rotate one step a cycle, then store the result
    always_ff @(posedge i_clk) begin
        case (r_state)
            mwpt_pkg::CS_LOAD: begin
                r_x    <= mwpt_pkg::CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= mwpt_pkg::CZ_W'($signed(z32));
                r_flip <= flip;
                r_cnt  <= '0;
            end
            mwpt_pkg::CS_ITER: begin
                if (!r_z[mwpt_pkg::CZ_W-1]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            mwpt_pkg::CS_DONE: begin
                r_cos <= mwpt_pkg::SC_W'(r_flip ? -r_x : r_x);
                r_sin <= mwpt_pkg::SC_W'(r_flip ? -r_y : r_y);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/mwpt_front.sv
`default_nettype none

module mwpt_front (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_en,
    input  wire                                 i_acc,
    input  wire mwpt_pkg::t_in                  i_in,
    input  wire        [mwpt_pkg::RES_W-1:0]    i_res,
    input  wire signed [mwpt_pkg::POS_W-1:0]    i_ox,
    input  wire signed [mwpt_pkg::POS_W-1:0]    i_oy,
    input  wire        [mwpt_pkg::ANG_W-1:0]    i_yaw,
    input  wire signed [mwpt_pkg::SC_W-1:0]     i_cos,
    input  wire signed [mwpt_pkg::SC_W-1:0]     i_sin,
    output logic                                o_valid,
    output mwpt_pkg::t_lane                     o_lane
);

    localparam logic signed [mwpt_pkg::SUM_W-1:0] HALF_R =
        mwpt_pkg::SUM_W'(1) <<< (mwpt_pkg::RND_SH - 1);
    localparam logic signed [mwpt_pkg::MP_W-1:0] HALF_S =
        mwpt_pkg::MP_W'(1) <<< (mwpt_pkg::SC_SH - 1);

    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v;

    // Stage A: origin offset for world to map, and heading
    logic                             r_a_cmd;
    logic signed [mwpt_pkg::AX_W-1:0] r_a_x, r_a_y, n_a_x, n_a_y;
    logic [mwpt_pkg::ANG_W-1:0]       r_a_hd, n_a_hd;

    always_comb begin
        if (i_in.cmd == mwpt_pkg::CMD_W2M) begin
            n_a_x  = mwpt_pkg::AX_W'(i_in.pose_x) - mwpt_pkg::AX_W'(i_ox);
            n_a_y  = mwpt_pkg::AX_W'(i_in.pose_y) - mwpt_pkg::AX_W'(i_oy);
            n_a_hd = i_in.heading - i_yaw;
        end else begin
            n_a_x  = mwpt_pkg::AX_W'(i_in.pose_x);
            n_a_y  = mwpt_pkg::AX_W'(i_in.pose_y);
            n_a_hd = i_in.heading + i_yaw;
        end
    end

    // Stage B: four rotation products
    logic                             r_b_cmd;
    logic [mwpt_pkg::ANG_W-1:0]       r_b_hd;
    logic signed [mwpt_pkg::PR_W-1:0] r_b_cx, r_b_sy, r_b_sx, r_b_cy;
    logic signed [mwpt_pkg::PR_W-1:0] n_b_cx, n_b_sy, n_b_sx, n_b_cy;

    always_comb begin
        n_b_cx = r_a_x * i_cos;
        n_b_sy = r_a_y * i_sin;
        n_b_sx = r_a_x * i_sin;
        n_b_cy = r_a_y * i_cos;
    end

    // Stage C: sums and rounding to Q.16
    logic                              r_c_cmd;
    logic [mwpt_pkg::ANG_W-1:0]        r_c_hd;
    logic signed [mwpt_pkg::R_W-1:0]   r_c_x, r_c_y;
    logic signed [mwpt_pkg::SUM_W-1:0] sum_x, sum_y;

    always_comb begin
        if (r_b_cmd == mwpt_pkg::CMD_W2M) begin
            sum_x = mwpt_pkg::SUM_W'(r_b_cx) + mwpt_pkg::SUM_W'(r_b_sy) + HALF_R;
            sum_y = mwpt_pkg::SUM_W'(r_b_cy) - mwpt_pkg::SUM_W'(r_b_sx) + HALF_R;
        end else begin
            sum_x = mwpt_pkg::SUM_W'(r_b_cx) - mwpt_pkg::SUM_W'(r_b_sy) + HALF_R;
            sum_y = mwpt_pkg::SUM_W'(r_b_sx) + mwpt_pkg::SUM_W'(r_b_cy) + HALF_R;
        end
    end

    // Stage D: scale by resolution, and build the dividends
    logic                              r_d_cmd;
    logic [mwpt_pkg::ANG_W-1:0]        r_d_hd;
    logic signed [mwpt_pkg::MP_W-1:0]  r_d_mx, r_d_my;
    logic [mwpt_pkg::DVD_W-1:0]        r_d_dx, r_d_dy;
    logic                              r_d_nx, r_d_ny;
    logic [mwpt_pkg::RES_W-1:0]        r_d_dv;
    logic [mwpt_pkg::RES_W-1:0]        dv;
    logic [mwpt_pkg::R_W-1:0]          mag_x, mag_y;

    always_comb begin
        dv    = (i_res == '0) ? mwpt_pkg::RES_W'(1) : i_res;
        mag_x = r_c_x[mwpt_pkg::R_W-1] ? mwpt_pkg::R_W'(-r_c_x) : r_c_x;
        mag_y = r_c_y[mwpt_pkg::R_W-1] ? mwpt_pkg::R_W'(-r_c_y) : r_c_y;
    end

    // Stage E: add origin and clip, and check quotient range
    logic signed [mwpt_pkg::MP_W-1:0] rs_x, rs_y;
    logic signed [mwpt_pkg::OS_W-1:0] os_x, os_y;
    logic                             cl_x, cl_y;
    logic [mwpt_pkg::POS_W-1:0]       v_x, v_y;
    logic [mwpt_pkg::REM_W-1:0]       lim;
    mwpt_pkg::t_lane                  r_e, n_e;

    always_comb begin
        rs_x = r_d_mx + HALF_S;
        rs_y = r_d_my + HALF_S;
        os_x = mwpt_pkg::OS_W'($signed(rs_x[mwpt_pkg::MP_W-1:mwpt_pkg::SC_SH]))
             + mwpt_pkg::OS_W'(i_ox);
        os_y = mwpt_pkg::OS_W'($signed(rs_y[mwpt_pkg::MP_W-1:mwpt_pkg::SC_SH]))
             + mwpt_pkg::OS_W'(i_oy);
        cl_x = !((&os_x[mwpt_pkg::OS_W-1:mwpt_pkg::POS_W-1])
               || !(|os_x[mwpt_pkg::OS_W-1:mwpt_pkg::POS_W-1]));
        cl_y = !((&os_y[mwpt_pkg::OS_W-1:mwpt_pkg::POS_W-1])
               || !(|os_y[mwpt_pkg::OS_W-1:mwpt_pkg::POS_W-1]));
        v_x  = cl_x ? {os_x[mwpt_pkg::OS_W-1], {(mwpt_pkg::POS_W-1){!os_x[mwpt_pkg::OS_W-1]}}}
                    : os_x[mwpt_pkg::POS_W-1:0];
        v_y  = cl_y ? {os_y[mwpt_pkg::OS_W-1], {(mwpt_pkg::POS_W-1){!os_y[mwpt_pkg::OS_W-1]}}}
                    : os_y[mwpt_pkg::POS_W-1:0];
        lim  = mwpt_pkg::REM_W'(r_d_dv) << mwpt_pkg::Q_W;

        n_e.cmd   = r_d_cmd;
        n_e.hd    = r_d_hd;
        n_e.mx    = v_x;
        n_e.my    = v_y;
        n_e.mclip = cl_x | cl_y;
        n_e.nx    = r_d_nx;
        n_e.ny    = r_d_ny;
        n_e.rx    = mwpt_pkg::REM_W'(r_d_dx);
        n_e.ry    = mwpt_pkg::REM_W'(r_d_dy);
        n_e.ovx   = mwpt_pkg::REM_W'(r_d_dx) >= lim;
        n_e.ovy   = mwpt_pkg::REM_W'(r_d_dy) >= lim;
        n_e.qx    = '0;
        n_e.qy    = '0;
        n_e.dv    = r_d_dv;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_acc;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    // Payload advances on every enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_cmd <= i_in.cmd;
            r_a_x   <= n_a_x;
            r_a_y   <= n_a_y;
            r_a_hd  <= n_a_hd;

            r_b_cmd <= r_a_cmd;
            r_b_hd  <= r_a_hd;
            r_b_cx  <= n_b_cx;
            r_b_sy  <= n_b_sy;
            r_b_sx  <= n_b_sx;
            r_b_cy  <= n_b_cy;

            r_c_cmd <= r_b_cmd;
            r_c_hd  <= r_b_hd;
            r_c_x   <= sum_x[mwpt_pkg::SUM_W-1:mwpt_pkg::RND_SH];
            r_c_y   <= sum_y[mwpt_pkg::SUM_W-1:mwpt_pkg::RND_SH];

            r_d_cmd <= r_c_cmd;
            r_d_hd  <= r_c_hd;
            r_d_mx  <= r_c_x * $signed({1'b0, i_res});
            r_d_my  <= r_c_y * $signed({1'b0, i_res});
            r_d_dx  <= {1'b0, mag_x, {mwpt_pkg::SC_SH{1'b0}}}
                     + mwpt_pkg::DVD_W'(dv >> 1);
            r_d_dy  <= {1'b0, mag_y, {mwpt_pkg::SC_SH{1'b0}}}
                     + mwpt_pkg::DVD_W'(dv >> 1);
            r_d_nx  <= r_c_x[mwpt_pkg::R_W-1];
            r_d_ny  <= r_c_y[mwpt_pkg::R_W-1];
            r_d_dv  <= dv;

            r_e     <= n_e;
        end
    end

    assign o_valid = r_e_v;
    assign o_lane  = r_e;

endmodule

`default_nettype wire

### rtl/core/mwpt_div.sv
`default_nettype none

module mwpt_div (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  wire mwpt_pkg::t_lane i_lane,
    output logic                 o_valid,
    output mwpt_pkg::t_lane      o_lane
);

    localparam int N = mwpt_pkg::Q_W;

    mwpt_pkg::t_lane r_st [N];
    logic            r_v  [N];

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int K = N - 1 - j;
        mwpt_pkg::t_lane            prev, nxt;
        logic                       prev_v;
        logic [mwpt_pkg::REM_W-1:0] sh;

        if (j == 0) begin : g_first
            assign prev   = i_lane;
            assign prev_v = i_valid;
        end else begin : g_next
            assign prev   = r_st[j-1];
            assign prev_v = r_v[j-1];
        end

        always_comb begin
            nxt = prev;
            sh  = mwpt_pkg::REM_W'(prev.dv) << K;
            if (prev.rx >= sh) begin
                nxt.rx    = prev.rx - sh;
                nxt.qx[K] = 1'b1;
            end
            if (prev.ry >= sh) begin
                nxt.ry    = prev.ry - sh;
                nxt.qy[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= prev_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j] <= nxt;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_lane  = r_st[N-1];

endmodule

`default_nettype wire

### rtl/core/map_world_pose_transform.sv
`default_nettype none

// Channel   Direction  Handshake               Beat
// in        input      i_in_valid / o_in_ready   mwpt_pkg::t_in
// out       output     o_out_valid / i_out_ready mwpt_pkg::t_out
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_wdata
//
// One pose per cycle while the output is not stalled and the sine/cosine unit is idle;
// each beat passes 5 front stages, 33 divider stages and the output register.
// Reset and a write of origin_yaw start the sine/cosine unit, which runs one
// CORDIC step a cycle; o_in_ready stays low while it loads, iterates and stores,
// after a yaw write and after reset is released.
// A stalled output beat freezes the whole pipeline; nothing is dropped.

module map_world_pose_transform #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire mwpt_pkg::t_in                    i_in_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output mwpt_pkg::t_out                        o_out_data,
    input  wire                                   i_cfg_we,
    input  wire [mwpt_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire [mwpt_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    logic [mwpt_pkg::RES_W-1:0]       r_res;
    logic signed [mwpt_pkg::POS_W-1:0] r_ox, r_oy;
    logic [mwpt_pkg::ANG_W-1:0]       r_yaw;

    logic signed [mwpt_pkg::SC_W-1:0] cosv, sinv;
    logic                             busy, en, acc, yaw_wr;
    logic                             f_v, d_v;
    mwpt_pkg::t_lane                  f_lane, d_lane;

    logic           r_out_v;
    mwpt_pkg::t_out r_out, n_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= mwpt_pkg::RES_W'(3277);
            r_ox  <= '0;
            r_oy  <= '0;
            r_yaw <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mwpt_pkg::CFG_RESOLUTION: r_res <= i_cfg_wdata[mwpt_pkg::RES_W-1:0];
                mwpt_pkg::CFG_ORIGIN_X:   r_ox  <= i_cfg_wdata[mwpt_pkg::POS_W-1:0];
                mwpt_pkg::CFG_ORIGIN_Y:   r_oy  <= i_cfg_wdata[mwpt_pkg::POS_W-1:0];
                mwpt_pkg::CFG_ORIGIN_YAW: r_yaw <= i_cfg_wdata[mwpt_pkg::ANG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign yaw_wr = i_cfg_we && (i_cfg_idx == mwpt_pkg::CFG_ORIGIN_YAW);

    // Advance the pipeline unless the output beat is held
    assign en         = !r_out_v || i_out_ready;
    assign o_in_ready = en && !busy;
    assign acc        = i_in_valid && o_in_ready;

    mwpt_cordic #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (yaw_wr),
        .i_yaw   (r_yaw),
        .o_cos   (cosv),
        .o_sin   (sinv),
        .o_busy  (busy)
    );

    mwpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_acc   (acc),
        .i_in    (i_in_data),
        .i_res   (r_res),
        .i_ox    (r_ox),
        .i_oy    (r_oy),
        .i_yaw   (r_yaw),
        .i_cos   (cosv),
        .i_sin   (sinv),
        .o_valid (f_v),
        .o_lane  (f_lane)
    );

    mwpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_lane  (f_lane),
        .o_valid (d_v),
        .o_lane  (d_lane)
    );

    // Sign and clip the quotients, or pass the scaled result
    logic                       cx, cy;
    logic [mwpt_pkg::POS_W-1:0] qx, qy, wx, wy;

    always_comb begin
        qx = d_lane.qx[mwpt_pkg::POS_W-1:0];
        qy = d_lane.qy[mwpt_pkg::POS_W-1:0];
        cx = d_lane.ovx || d_lane.qx[mwpt_pkg::Q_W-1]
           || (d_lane.nx ? (qx[mwpt_pkg::POS_W-1] && (|qx[mwpt_pkg::POS_W-2:0]))
                         : qx[mwpt_pkg::POS_W-1]);
        cy = d_lane.ovy || d_lane.qy[mwpt_pkg::Q_W-1]
           || (d_lane.ny ? (qy[mwpt_pkg::POS_W-1] && (|qy[mwpt_pkg::POS_W-2:0]))
                         : qy[mwpt_pkg::POS_W-1]);
        if (cx) wx = {d_lane.nx, {(mwpt_pkg::POS_W-1){!d_lane.nx}}};
        else    wx = d_lane.nx ? -qx : qx;
        if (cy) wy = {d_lane.ny, {(mwpt_pkg::POS_W-1){!d_lane.ny}}};
        else    wy = d_lane.ny ? -qy : qy;

        n_out.out_heading = d_lane.hd;
        if (d_lane.cmd == mwpt_pkg::CMD_W2M) begin
            n_out.out_x     = wx;
            n_out.out_y     = wy;
            n_out.saturated = cx | cy;
        end else begin
            n_out.out_x     = d_lane.mx;
            n_out.out_y     = d_lane.my;
            n_out.saturated = d_lane.mclip;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### rtl/core/mwpt_checker.sv
`default_nettype none

module mwpt_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             o_in_ready,
    input wire                             o_out_valid,
    input wire                             i_out_ready,
    input wire mwpt_pkg::t_out             o_out_data,
    input wire                             i_cfg_we,
    input wire [mwpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx
);

    // Held output beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // A held output beat freezes the input side
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken during output stall");

    // Yaw write restarts the sine/cosine unit
    a_yaw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx == mwpt_pkg::CFG_ORIGIN_YAW) |=> !o_in_ready)
        else $error("input taken while sine/cosine recomputes");

    // Nothing leaves or is taken straight after reset
    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_ready)
        else $error("beat present after reset");

endmodule

bind map_world_pose_transform mwpt_checker u_mwpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx)
);

`default_nettype wire
